// ===== rtl/core/ssrp_pkg.sv =====
// shared types, register codes and reset values for the soft-start regulator
package ssrp_pkg;

    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 16;

    localparam int LevelW   = 12;
    localparam int DutyW    = 10;
    localparam int DeadW    = 8;
    localparam int TickW    = 8;
    localparam int ProtW    = 16;
    localparam int CmpHighW = 12;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_TARGET_LEVEL  = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_START_LEVEL   = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_SHORT_LEVEL   = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_START_DUTY    = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_DEADBAND      = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_START_TICKS   = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_SHORT_TICKS   = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_PROTECT_TICKS = 4'd7;

    localparam logic [LevelW-1:0] RST_TARGET_LEVEL  = 12'd1730;
    localparam logic [LevelW-1:0] RST_START_LEVEL   = 12'd400;
    localparam logic [LevelW-1:0] RST_SHORT_LEVEL   = 12'd1000;
    localparam logic [DutyW-1:0]  RST_START_DUTY    = 10'd50;
    localparam logic [DeadW-1:0]  RST_DEADBAND      = 8'd20;
    localparam logic [TickW-1:0]  RST_START_TICKS   = 8'd10;
    localparam logic [TickW-1:0]  RST_SHORT_TICKS   = 8'd3;
    localparam logic [ProtW-1:0]  RST_PROTECT_TICKS = 16'd3000;

    typedef struct packed {
        logic [LevelW-1:0] target_level;
        logic [LevelW-1:0] start_level;
        logic [LevelW-1:0] short_level;
        logic [DutyW-1:0]  start_duty;
        logic [DeadW-1:0]  deadband;
        logic [TickW-1:0]  start_ticks;
        logic [TickW-1:0]  short_ticks;
        logic [ProtW-1:0]  protect_ticks;
    } ssrp_cfg_t;

endpackage

// ===== rtl/core/ssrp_cfg_regs.sv =====
// configuration register bank with write decode
module ssrp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssrp_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ssrp_pkg::CfgDataW-1:0]  cfg_data,
    output ssrp_pkg::ssrp_cfg_t            cfg
);

    ssrp_pkg::ssrp_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level  <= ssrp_pkg::RST_TARGET_LEVEL;
            cfg_reg.start_level   <= ssrp_pkg::RST_START_LEVEL;
            cfg_reg.short_level   <= ssrp_pkg::RST_SHORT_LEVEL;
            cfg_reg.start_duty    <= ssrp_pkg::RST_START_DUTY;
            cfg_reg.deadband      <= ssrp_pkg::RST_DEADBAND;
            cfg_reg.start_ticks   <= ssrp_pkg::RST_START_TICKS;
            cfg_reg.short_ticks   <= ssrp_pkg::RST_SHORT_TICKS;
            cfg_reg.protect_ticks <= ssrp_pkg::RST_PROTECT_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes past the list are dropped
            case (cfg_index)
                ssrp_pkg::REG_TARGET_LEVEL:
                    cfg_reg.target_level <= cfg_data[ssrp_pkg::LevelW-1:0];
                ssrp_pkg::REG_START_LEVEL:
                    cfg_reg.start_level <= cfg_data[ssrp_pkg::LevelW-1:0];
                ssrp_pkg::REG_SHORT_LEVEL:
                    cfg_reg.short_level <= cfg_data[ssrp_pkg::LevelW-1:0];
                ssrp_pkg::REG_START_DUTY:
                    cfg_reg.start_duty <= cfg_data[ssrp_pkg::DutyW-1:0];
                ssrp_pkg::REG_DEADBAND:
                    cfg_reg.deadband <= cfg_data[ssrp_pkg::DeadW-1:0];
                ssrp_pkg::REG_START_TICKS:
                    cfg_reg.start_ticks <= cfg_data[ssrp_pkg::TickW-1:0];
                ssrp_pkg::REG_SHORT_TICKS:
                    cfg_reg.short_ticks <= cfg_data[ssrp_pkg::TickW-1:0];
                ssrp_pkg::REG_PROTECT_TICKS:
                    cfg_reg.protect_ticks <= cfg_data[ssrp_pkg::ProtW-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/ssrp_ctrl.sv =====
// mode supervisor, duty regulation, heartbeat and registered compare outputs
module ssrp_ctrl #(
    parameter int PWM_PERIOD  = 250,
    parameter int BLINK_TICKS = 2000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [ssrp_pkg::LevelW-1:0]     sample,
    input  ssrp_pkg::ssrp_cfg_t             cfg,
    output logic [ssrp_pkg::DutyW-1:0]      compare_low,
    output logic [ssrp_pkg::CmpHighW-1:0]   compare_high,
    output logic [1:0]                      mode,
    output logic [ssrp_pkg::DutyW-1:0]      duty_now,
    output logic                            led_level
);

    localparam int BlinkW = $clog2(BLINK_TICKS + 1);
    localparam logic [BlinkW-1:0] BlinkLimit = BlinkW'(BLINK_TICKS);
    localparam logic [ssrp_pkg::DutyW-1:0] Period = ssrp_pkg::DutyW'(PWM_PERIOD);
    localparam logic [ssrp_pkg::CmpHighW-1:0] TwoPeriod =
        ssrp_pkg::CmpHighW'(2 * PWM_PERIOD);

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_CHECK   = 2'd1,
        MODE_RUN     = 2'd2,
        MODE_PROTECT = 2'd3
    } mode_t;

    mode_t                            mode_reg, mode_next;
    logic [ssrp_pkg::DutyW-1:0]       duty_reg, duty_next;
    logic [ssrp_pkg::TickW-1:0]       start_count_reg, start_count_next;
    logic [ssrp_pkg::TickW-1:0]       short_count_reg, short_count_next;
    logic [ssrp_pkg::ProtW-1:0]       protect_count_reg, protect_count_next;
    logic [BlinkW-1:0]                blink_count_reg, blink_count_next;
    logic                             led_reg, led_next;
    logic [ssrp_pkg::DutyW-1:0]       compare_low_reg, compare_low_next;
    logic [ssrp_pkg::CmpHighW-1:0]    compare_high_reg, compare_high_next;

    logic [ssrp_pkg::DutyW:0]         start_sum;
    logic [ssrp_pkg::DutyW-1:0]       dead_ext;
    logic [ssrp_pkg::TickW-1:0]       start_inc, short_inc;
    logic [ssrp_pkg::ProtW-1:0]       protect_inc;
    logic [BlinkW-1:0]                blink_inc;
    logic [ssrp_pkg::CmpHighW-1:0]    hi_base, duty_wide;

    assign dead_ext = ssrp_pkg::DutyW'(cfg.deadband);

    always_comb
    begin
        mode_next          = mode_reg;
        duty_next          = duty_reg;
        start_count_next   = start_count_reg;
        short_count_next   = short_count_reg;
        protect_count_next = protect_count_reg;
        led_next           = led_reg;

        // counters stay below their limit, so the increments never carry out
        start_inc   = start_count_reg + 1'b1;
        short_inc   = short_count_reg + 1'b1;
        protect_inc = protect_count_reg + 1'b1;
        blink_inc   = blink_count_reg + 1'b1;
        start_sum   = {1'b0, dead_ext} + {1'b0, cfg.start_duty};

        blink_count_next = blink_inc;
        if (blink_inc >= BlinkLimit)
        begin
            blink_count_next = '0;
            led_next         = ~led_reg;
        end

        case (mode_reg)
            MODE_START:
            begin
                duty_next = (start_sum > {1'b0, Period}) ? Period
                                                         : start_sum[ssrp_pkg::DutyW-1:0];
                start_count_next = start_inc;
                if (start_inc >= cfg.start_ticks)
                begin
                    start_count_next = '0;
                    mode_next        = MODE_CHECK;
                end
            end
            MODE_CHECK:
            begin
                if (sample > cfg.start_level)
                begin
                    mode_next = MODE_RUN;
                end
                else
                begin
                    duty_next = dead_ext;
                    mode_next = MODE_PROTECT;
                end
            end
            MODE_RUN:
            begin
                if (sample > cfg.target_level)
                begin
                    duty_next = (duty_reg <= dead_ext) ? dead_ext : duty_reg - 1'b1;
                end
                else if (sample < cfg.target_level)
                begin
                    duty_next = (duty_reg >= Period) ? Period : duty_reg + 1'b1;
                end
                // short detection overrides the regulation step
                if (sample < cfg.short_level)
                begin
                    short_count_next = short_inc;
                    if (short_inc >= cfg.short_ticks)
                    begin
                        short_count_next = '0;
                        duty_next        = dead_ext;
                        mode_next        = MODE_PROTECT;
                    end
                end
                else
                begin
                    short_count_next = '0;
                end
            end
            default:
            begin
                protect_count_next = protect_inc;
                if (protect_inc >= cfg.protect_ticks)
                begin
                    protect_count_next = '0;
                    mode_next          = MODE_START;
                end
            end
        endcase

        // compare values floor at zero
        compare_low_next = (duty_next >= dead_ext) ? duty_next - dead_ext : '0;
        hi_base   = TwoPeriod + ssrp_pkg::CmpHighW'(cfg.deadband);
        duty_wide = ssrp_pkg::CmpHighW'(duty_next);
        compare_high_next = (hi_base >= duty_wide) ? hi_base - duty_wide : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_START;
            duty_reg          <= '0;
            start_count_reg   <= '0;
            short_count_reg   <= '0;
            protect_count_reg <= '0;
            blink_count_reg   <= '0;
            led_reg           <= 1'b0;
            compare_low_reg   <= '0;
            compare_high_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            duty_reg          <= duty_next;
            start_count_reg   <= start_count_next;
            short_count_reg   <= short_count_next;
            protect_count_reg <= protect_count_next;
            blink_count_reg   <= blink_count_next;
            led_reg           <= led_next;
            compare_low_reg   <= compare_low_next;
            compare_high_reg  <= compare_high_next;
        end
    end

    assign compare_low  = compare_low_reg;
    assign compare_high = compare_high_reg;
    assign mode         = mode_reg;
    assign duty_now     = duty_reg;
    assign led_level    = led_reg;

endmodule

// ===== rtl/core/supply_softstart_regulator_protect.sv =====
// soft-start supply regulator with short protection, top level
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall    sample
//  out      from block out_valid / out_stall  compare_low, compare_high, mode,
//                                             duty_now, led_level
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample per clock while in_stall is low; its result appears in the cycle after the transaction
// and the whole tick update runs in the single stage behind the output register
// reset puts the supervisor in soft start with zero duty and default registers
// in_stall is raised only while a result is held and out_stall is high
module supply_softstart_regulator_protect #(
    parameter int PWM_PERIOD  = 250,
    parameter int BLINK_TICKS = 2000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ssrp_pkg::LevelW-1:0]     sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssrp_pkg::DutyW-1:0]      compare_low,
    output logic [ssrp_pkg::CmpHighW-1:0]   compare_high,
    output logic [1:0]                      mode,
    output logic [ssrp_pkg::DutyW-1:0]      duty_now,
    output logic                            led_level,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssrp_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [ssrp_pkg::CfgDataW-1:0]   cfg_data
);

    ssrp_pkg::ssrp_cfg_t cfg;
    logic                out_valid_reg, out_valid_next;
    logic                in_accept;

    assign in_stall       = out_valid_reg & out_stall;
    assign in_accept      = in_valid & ~in_stall;
    assign out_valid_next = in_accept | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    ssrp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssrp_ctrl #(
        .PWM_PERIOD  (PWM_PERIOD),
        .BLINK_TICKS (BLINK_TICKS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_accept),
        .sample       (sample),
        .cfg          (cfg),
        .compare_low  (compare_low),
        .compare_high (compare_high),
        .mode         (mode),
        .duty_now     (duty_now),
        .led_level    (led_level)
    );

endmodule
